// ===== rtl/sorted_table_equal_range_search_macros.svh =====
// assertion macros shared by the checker of the equal-range search block
// expects signals named clock and reset in the scope where a macro is used
`ifndef SORTED_TABLE_EQUAL_RANGE_SEARCH_MACROS_SVH
`define SORTED_TABLE_EQUAL_RANGE_SEARCH_MACROS_SVH

// condition implies consequence in the same cycle
`define STEQR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the following cycle
`define STEQR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/steqr_pkg.sv =====
// shared types and constants of the equal-range search block
// no dependencies
`timescale 1ns / 1ps

package steqr_pkg;

   localparam int ENTRIES_W = 9;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int DATA_W    = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOWER,
      ST_UPPER,
      ST_CHECK_RD,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic mem_wr;    // store the write beat's entry
      logic start;     // capture key, open lower-bound search
      logic search;    // one bisection step
      logic strict;    // upper-bound compare
      logic save_lb;   // keep lower bound, reopen range for upper bound
      logic save_ub;   // keep upper bound
      logic rd_lb;     // read entry at the lower bound
      logic load_rsp;  // fill the response register
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
   } dp_sts_type;

endpackage

// ===== rtl/sorted_table_equal_range_search.sv =====
// top level of the sorted-table equal-range search block
// depends on steqr_pkg, steqr_ctrl and steqr_dpath
`timescale 1ns / 1ps
//
// usage
//  - req channel: opcode OP_WRITE stores entry_value at entry_index, opcode OP_QUERY
//    searches search_key over the first entries_in_use entries (saturated at TABLE_DEPTH)
//  - csr channel: writes entries_in_use, always ready, write only while no query is in flight
//  - rsp channel: one beat per query, none per write; found, first and last index of the
//    key and its occurrence count, all zero on a miss
//  - a write beat leaves the block idle; it is ready again on the next cycle
//  - a query runs a lower-bound and an upper-bound bisection on the single read port of
//    the entry memory, one step per cycle, then one read to confirm the lower-bound entry;
//    the block accepts no new beat until the query has loaded its response
//  - the response sits in an output register; a stalled receiver does not block the next
//    beat from being accepted, only the load of a second response waits for the first
//  - reset clears the controller, the response valid and entries_in_use; table contents
//    are undefined until written and need no clearing
//  - results carry meaning only for a table loaded in ascending order
//
module sorted_table_equal_range_search #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [steqr_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [steqr_pkg::DATA_W-1:0]  req_entry_value,
   input  logic signed [steqr_pkg::DATA_W-1:0]  req_search_key,
   // config channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [steqr_pkg::ENTRIES_W-1:0]      csr_entries_in_use,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [steqr_pkg::INDEX_W-1:0]        rsp_first_index,
   output logic [steqr_pkg::INDEX_W-1:0]        rsp_last_index,
   output logic [steqr_pkg::COUNT_W-1:0]        rsp_occurrence_count
);
   import steqr_pkg::*;

   // command and status between controller and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // controller: state machine, request ready, response valid
   steqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: entry memory, bisection bounds, config and response registers
   steqr_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .req_search_key       (req_search_key),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_entries_in_use   (csr_entries_in_use),
      .rsp_found            (rsp_found),
      .rsp_first_index      (rsp_first_index),
      .rsp_last_index       (rsp_last_index),
      .rsp_occurrence_count (rsp_occurrence_count)
   );

endmodule

// ===== rtl/steqr_dpath.sv =====
// datapath: entry memory, bisection registers, config register, response register
// depends on steqr_pkg
`timescale 1ns / 1ps

module steqr_dpath #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  steqr_pkg::dp_cmd_type                cmd,
   output steqr_pkg::dp_sts_type                sts,
   input  logic [steqr_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [steqr_pkg::DATA_W-1:0]  req_entry_value,
   input  logic signed [steqr_pkg::DATA_W-1:0]  req_search_key,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [steqr_pkg::ENTRIES_W-1:0]      csr_entries_in_use,
   output logic                                 rsp_found,
   output logic [steqr_pkg::INDEX_W-1:0]        rsp_first_index,
   output logic [steqr_pkg::INDEX_W-1:0]        rsp_last_index,
   output logic [steqr_pkg::COUNT_W-1:0]        rsp_occurrence_count
);
   import steqr_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = (CW > ENTRIES_W) ? CW : ENTRIES_W;
   localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hi_ff;
   logic [CW-1:0]          lb_ff;
   logic [CW-1:0]          ub_ff;
   logic [AW-1:0]          mid_ff;
   logic                   pend_ff;
   logic                   pend_in;
   logic [ENTRIES_W-1:0]   entries_ff;

   logic [NW-1:0]          entries_ext;
   logic [CW-1:0]          n_sat;
   logic [VALUE_WIDTH-1:0] wr_val;
   logic [VALUE_WIDTH-1:0] key_val;
   logic                   wr_ok;
   logic                   go_right;
   logic [CW-1:0]          lo_e;
   logic [CW-1:0]          hi_e;
   logic [CW-1:0]          mid_e;
   logic                   done;
   logic [AW-1:0]          rd_addr;
   logic                   rd_en;
   logic                   hit;
   logic [OW-1:0]          lb_ext;
   logic [OW-1:0]          ub_m1;
   logic [OW-1:0]          diff;

   assign csr_ready = 1'b1;

   // searched length, saturated at the table depth
   assign entries_ext = NW'(entries_ff);
   assign n_sat = (entries_ext > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entries_ext);

   // order-preserving unsigned form: sign bit flipped
   assign wr_val  = VALUE_WIDTH'($unsigned(req_entry_value)) ^ SIGN_BIT;
   assign key_val = VALUE_WIDTH'($unsigned(req_search_key)) ^ SIGN_BIT;
   assign wr_ok   = 32'(req_entry_index) < 32'(TABLE_DEPTH);

   // resolve the outstanding read, then bisect the narrowed range
   always_comb begin
      go_right = cmd.strict ? (rdata_ff <= key_ff) : (rdata_ff < key_ff);
      lo_e = (pend_ff && go_right) ? CW'(mid_ff) + CW'(1) : lo_ff;
      hi_e = (pend_ff && !go_right) ? CW'(mid_ff) : hi_ff;
      done = !(lo_e < hi_e);
      mid_e = lo_e + ((hi_e - lo_e) >> 1);
      rd_addr = cmd.rd_lb ? AW'(lb_ff) : AW'(mid_e);
      rd_en = cmd.search | cmd.rd_lb;
   end

   assign sts.search_done = done;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_ok) begin
         mem[AW'(req_entry_index)] <= wr_val;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (cmd.start || cmd.save_lb) begin
         pend_in = 1'b0;
      end else if (cmd.search) begin
         pend_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         entries_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_entries_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= key_val;
         lo_ff  <= '0;
         hi_ff  <= n_sat;
      end else if (cmd.save_lb) begin
         lb_ff <= lo_e;
         lo_ff <= '0;
         hi_ff <= n_sat;
      end else if (cmd.search) begin
         lo_ff  <= lo_e;
         hi_ff  <= hi_e;
         mid_ff <= AW'(mid_e);
      end
      if (cmd.save_ub) begin
         ub_ff <= lo_e;
      end
   end

   // rdata_ff holds the entry at the lower bound here
   assign hit    = (lb_ff < n_sat) && (rdata_ff == key_ff) && (ub_ff > lb_ff);
   assign lb_ext = OW'(lb_ff);
   assign ub_m1  = OW'(ub_ff) - OW'(1);
   assign diff   = OW'(ub_ff) - OW'(lb_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found            <= hit;
         rsp_first_index      <= hit ? lb_ext[INDEX_W-1:0] : '0;
         rsp_last_index       <= hit ? ub_m1[INDEX_W-1:0] : '0;
         rsp_occurrence_count <= hit ? diff[COUNT_W-1:0] : '0;
      end
   end

endmodule

// ===== rtl/steqr_ctrl.sv =====
// controller: sequences write, lower-bound search, upper-bound search, check and response
// depends on steqr_pkg
`timescale 1ns / 1ps

module steqr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output steqr_pkg::dp_cmd_type cmd,
   input  steqr_pkg::dp_sts_type sts
);
   import steqr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = ST_LOWER;
               end else begin
                  cmd.mem_wr = 1'b1;
               end
            end
         end
         ST_LOWER: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               cmd.save_lb = 1'b1;
               state_in    = ST_UPPER;
            end
         end
         ST_UPPER: begin
            cmd.search = 1'b1;
            cmd.strict = 1'b1;
            if (sts.search_done) begin
               cmd.save_ub = 1'b1;
               state_in    = ST_CHECK_RD;
            end
         end
         ST_CHECK_RD: begin
            cmd.rd_lb = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/steqr_checker.sv =====
// port-level checker of the equal-range search block, bound to the top level
// depends on steqr_pkg and sorted_table_equal_range_search_macros.svh
`timescale 1ns / 1ps
`include "sorted_table_equal_range_search_macros.svh"

module steqr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_found,
   input logic [steqr_pkg::INDEX_W-1:0]   rsp_first_index,
   input logic [steqr_pkg::INDEX_W-1:0]   rsp_last_index,
   input logic [steqr_pkg::COUNT_W-1:0]   rsp_occurrence_count
);
   import steqr_pkg::*;

   // stalled response beat holds
   `STEQR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_first_index) &&
      $stable(rsp_last_index) && $stable(rsp_occurrence_count),
      "response changed while stalled")

   // a miss reports all zero
   `STEQR_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found,
      rsp_first_index == '0 && rsp_last_index == '0 && rsp_occurrence_count == '0,
      "miss with nonzero fields")

   // a hit spans last minus first plus one entries
   `STEQR_ASSERT_NOW(a_hit_span, rsp_valid && rsp_found,
      rsp_occurrence_count ==
      ({1'b0, rsp_last_index} - {1'b0, rsp_first_index} + 9'd1),
      "occurrence count does not match index span")

   // a write never produces a response
   `STEQR_ASSERT_NEXT(a_write_silent,
      req_valid && req_ready && req_opcode == OP_WRITE && !rsp_valid,
      !rsp_valid, "response after a write beat")

   // a query occupies the block
   `STEQR_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_opcode == OP_QUERY,
      !req_ready, "ready right after a query beat")

endmodule

bind sorted_table_equal_range_search steqr_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_opcode           (req_opcode),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_found            (rsp_found),
   .rsp_first_index      (rsp_first_index),
   .rsp_last_index       (rsp_last_index),
   .rsp_occurrence_count (rsp_occurrence_count)
);
